@@ hdl/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define CLS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define CLS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/cls_pkg.sv @@
package cls_pkg;

  typedef logic [2:0] op_t;
  localparam op_t OP_INIT   = 3'd0;
  localparam op_t OP_CMD    = 3'd1;
  localparam op_t OP_DATA   = 3'd2;
  localparam op_t OP_CURSOR = 3'd3;
  localparam op_t OP_CLEAR  = 3'd4;

  localparam logic [15:0] PULSE_HIGH_US  = 16'd1;
  localparam logic [15:0] PULSE_LOW_US   = 16'd50;
  localparam logic [15:0] CMD_TAIL_US    = 16'd100;
  localparam logic [15:0] DATA_TAIL_US   = 16'd50;
  localparam logic [15:0] CLEAR_TAIL_US  = 16'd2100;
  localparam logic [15:0] POWERUP_US     = 16'd50000;

  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [6:0] DDRAM_ADDR_MSK = 7'h7F;

  localparam logic [4:0] INIT_LAST_SEG = 5'd28;
  localparam logic [4:0] BYTE_LAST_SEG = 5'd3;

  // Latched request, resolved at accept time.
  typedef struct packed {
    logic        is_init;
    logic        rs;
    logic [7:0]  byte_val;
    logic [15:0] tail_us;
  } req_t;

  // Segment description before the hold add.
  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] base_us;
    logic [15:0] extra_us;
    logic        last;
  } seg_desc_t;

  // Finished segment as driven onto the result channel.
  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold_us;
    logic        last;
  } seg_out_t;

  typedef struct packed {
    logic [3:0]  nib;
    logic [15:0] extra_us;
  } init_nib_t;

  function automatic logic [6:0] row_base(input logic [1:0] row);
    logic [6:0] b;
    case (row)
      2'd0:    b = 7'h00;
      2'd1:    b = 7'h40;
      2'd2:    b = 7'h14;
      default: b = 7'h54;
    endcase
    return b;
  endfunction

  // Wake-up nibble list, fourteen nibbles after the idle segment.
  function automatic init_nib_t init_nib(input logic [3:0] idx);
    init_nib_t r;
    case (idx)
      4'd0:    r = '{nib: 4'h3, extra_us: 16'd5000};
      4'd1:    r = '{nib: 4'h3, extra_us: 16'd1000};
      4'd2:    r = '{nib: 4'h3, extra_us: 16'd0};
      4'd3:    r = '{nib: 4'h2, extra_us: 16'd0};
      4'd4:    r = '{nib: 4'h2, extra_us: 16'd0};
      4'd5:    r = '{nib: 4'h8, extra_us: CMD_TAIL_US};
      4'd6:    r = '{nib: 4'h0, extra_us: 16'd0};
      4'd7:    r = '{nib: 4'h8, extra_us: CMD_TAIL_US};
      4'd8:    r = '{nib: 4'h0, extra_us: 16'd0};
      4'd9:    r = '{nib: 4'h1, extra_us: CLEAR_TAIL_US};
      4'd10:   r = '{nib: 4'h0, extra_us: 16'd0};
      4'd11:   r = '{nib: 4'h6, extra_us: CMD_TAIL_US};
      4'd12:   r = '{nib: 4'h0, extra_us: 16'd0};
      4'd13:   r = '{nib: 4'hC, extra_us: CMD_TAIL_US};
      default: r = '{nib: 4'h0, extra_us: 16'd0};
    endcase
    return r;
  endfunction

endpackage

@@ hdl/cls_script.sv @@
module cls_script (
  input  cls_pkg::req_t      req,
  input  logic [4:0]         seg_idx,
  output cls_pkg::seg_desc_t desc
);

  logic [4:0]          init_idx;
  cls_pkg::init_nib_t  init_e;
  logic                byte_lo;

  assign init_idx = 5'(seg_idx - 5'd1);
  assign init_e   = cls_pkg::init_nib(init_idx[4:1]);
  assign byte_lo  = seg_idx[1];

  always_comb begin
    desc = '0;
    if (req.is_init) begin
      if (seg_idx == 5'd0) begin
        // power-up idle: everything low
        desc.base_us  = 16'd0;
        desc.extra_us = cls_pkg::POWERUP_US;
      end else begin
        desc.en       = ~init_idx[0];
        desc.nib      = init_e.nib;
        desc.base_us  = init_idx[0] ? cls_pkg::PULSE_LOW_US : cls_pkg::PULSE_HIGH_US;
        desc.extra_us = init_idx[0] ? init_e.extra_us : 16'd0;
      end
      desc.last = (seg_idx == cls_pkg::INIT_LAST_SEG);
    end else begin
      desc.rs       = req.rs;
      desc.en       = ~seg_idx[0];
      desc.nib      = byte_lo ? req.byte_val[3:0] : req.byte_val[7:4];
      desc.base_us  = seg_idx[0] ? cls_pkg::PULSE_LOW_US : cls_pkg::PULSE_HIGH_US;
      desc.extra_us = (byte_lo && seg_idx[0]) ? req.tail_us : 16'd0;
      desc.last     = (seg_idx == cls_pkg::BYTE_LAST_SEG);
    end
  end

endmodule

@@ hdl/cls_seq.sv @@
module cls_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  cls_pkg::op_t      op,
  input  logic [7:0]        byte_value,
  input  logic [1:0]        row,
  input  logic [5:0]        column,
  output logic              seg_valid,
  input  logic              seg_ready,
  output cls_pkg::seg_out_t seg
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [4:0]         seg_r, seg_nxt;
  cls_pkg::req_t      req_r, req_nxt;
  cls_pkg::seg_desc_t desc;
  logic [6:0]         ddram_addr;

  cls_script u_script (
    .req     (req_r),
    .seg_idx (seg_r),
    .desc    (desc)
  );

  assign ddram_addr = 7'(7'(column) + cls_pkg::row_base(row)) & cls_pkg::DDRAM_ADDR_MSK;

  assign req_ready = (state_r == ST_IDLE);
  assign seg_valid = (state_r == ST_RUN);

  // shared hold adder: pulse base plus trailing delay
  assign seg.rs      = desc.rs;
  assign seg.en      = desc.en;
  assign seg.nib     = desc.nib;
  assign seg.hold_us = 16'(desc.base_us + desc.extra_us);
  assign seg.last    = desc.last;

  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    req_nxt   = req_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          seg_nxt           = 5'd0;
          req_nxt.is_init   = 1'b0;
          req_nxt.rs        = 1'b0;
          req_nxt.byte_val  = byte_value;
          req_nxt.tail_us   = cls_pkg::CMD_TAIL_US;
          state_nxt         = ST_RUN;
          case (op)
            cls_pkg::OP_INIT: begin
              req_nxt.is_init = 1'b1;
            end
            cls_pkg::OP_CMD: begin
            end
            cls_pkg::OP_DATA: begin
              req_nxt.rs      = 1'b1;
              req_nxt.tail_us = cls_pkg::DATA_TAIL_US;
            end
            cls_pkg::OP_CURSOR: begin
              req_nxt.byte_val = cls_pkg::CMD_SET_DDRAM | {1'b0, ddram_addr};
            end
            cls_pkg::OP_CLEAR: begin
              req_nxt.byte_val = cls_pkg::CMD_CLEAR;
              req_nxt.tail_us  = cls_pkg::CLEAR_TAIL_US;
            end
            default: begin
              // unknown operation: drop it
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (seg_ready) begin
          if (desc.last) begin
            state_nxt = ST_IDLE;
          end else begin
            seg_nxt = 5'(seg_r + 5'd1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seg_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
    end
    req_r <= req_nxt;
  end

endmodule

@@ hdl/char_lcd_4bit_bus_sequencer_top.sv @@
// First segment path: the request is latched in the sequencer, then loaded into the output register.
// Throughput: one segment per cycle from the segment counter while the output is not stalled;
// init takes 29 segments, byte requests 4, and an unknown operation is dropped with none.
// The input stays not ready while a request is being sequenced.
// Reset: synchronous active-low rst_n clears the sequencer state and counter and the output valid.
`include "assert_macros.svh"

module char_lcd_4bit_bus_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operation[2:0], byte_value[10:3], row[12:11], column[18:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // rs[0], enable[1], nibble[5:2], hold_us[21:6]
  output logic        out_tlast
);

  logic              seg_valid;
  logic              seg_ready;
  cls_pkg::seg_out_t seg;

  // Output holding register; the sequencer advances only when it is free or draining.
  logic              out_valid_r, out_valid_nxt;
  cls_pkg::seg_out_t out_seg_r, out_seg_nxt;

  cls_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .op         (in_tdata[2:0]),
    .byte_value (in_tdata[10:3]),
    .row        (in_tdata[12:11]),
    .column     (in_tdata[18:13]),
    .seg_valid  (seg_valid),
    .seg_ready  (seg_ready),
    .seg        (seg)
  );

  assign seg_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_seg_nxt   = out_seg_r;
    if (seg_ready) begin
      // load the next segment, or drop valid once the current one is taken
      out_valid_nxt = seg_valid;
      if (seg_valid) begin
        out_seg_nxt = seg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_seg_r <= out_seg_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_seg_r.last;
  assign out_tdata  = {2'b00, out_seg_r.hold_us, out_seg_r.nib, out_seg_r.en, out_seg_r.rs};

  // Hold an enable pulse for exactly the strobe width.
  `CLS_ASSERT(a_en_pulse_width, clk, rst_n, out_tvalid && out_tdata[1] |-> out_tdata[21:6] == cls_pkg::PULSE_HIGH_US, "enable segment hold is not the pulse width")
  // Never accept a new request while the sequencer still emits segments.
  `CLS_ASSERT(a_no_accept_busy, clk, rst_n, in_tready |-> !seg_valid, "input ready while segments pending")
  // A request never ends on the enable-high half of a nibble.
  `CLS_ASSERT(a_last_en_low, clk, rst_n, out_tvalid && out_tlast |-> !out_tdata[1], "last segment has enable high")

endmodule
